FILE: sv/plti_pkg.sv
// Shared constants for the piecewise linear table interpolator.
`timescale 1ns / 1ps
`default_nettype none

package plti_pkg;

    localparam int DATA_W          = 32;
    localparam int IDX_IN_W        = 6;
    localparam int CFG_W           = 7;
    localparam int KIND_W          = 2;
    localparam int TABLE_DEPTH_DEF = 64;

    localparam logic [CFG_W-1:0] POINTS_RESET = 7'd2;

    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    localparam logic [KIND_W-1:0] KIND_INTERP = 2'd0;
    localparam logic [KIND_W-1:0] KIND_FIRST  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_LAST   = 2'd2;

    typedef logic signed [DATA_W-1:0] sample_t;

endpackage

`default_nettype wire

FILE: sv/piecewise_linear_table_interpolator_core.sv
// Top level: breakpoint table with serial search, multiply and divide.
//
//   channel   direction   handshake          payload
//   s_        in          s_valid/s_ready    cmd, point_index, point_x, point_y, query_x
//   m_        out         m_valid/m_ready    result_y, segment_kind
//   cfg_      in          cfg_wr_en          cfg_wr_data (points_in_use)
//
// A write request is done in its handshake cycle and leaves the block idle. A query
// runs table setup, a serial scan of the breakpoints (up to points_in_use), a shift-add
// multiply, a restoring divide and a finish step before its result is offered.
// Reset is synchronous; table contents are not cleared. A result waiting on
// m_ready does not block the next request; a query finishing meanwhile waits.
`timescale 1ns / 1ps
`default_nettype none

module piecewise_linear_table_interpolator_core #(
    parameter int TABLE_DEPTH = plti_pkg::TABLE_DEPTH_DEF
) (
    input  wire                                aclk,
    input  wire                                aresetn,
    input  wire                                s_valid,
    output logic                               s_ready,
    input  wire                                s_cmd,
    input  wire  [plti_pkg::IDX_IN_W-1:0]      s_point_index,
    input  wire  signed [plti_pkg::DATA_W-1:0] s_point_x,
    input  wire  signed [plti_pkg::DATA_W-1:0] s_point_y,
    input  wire  signed [plti_pkg::DATA_W-1:0] s_query_x,
    output logic                               m_valid,
    input  wire                                m_ready,
    output logic signed [plti_pkg::DATA_W-1:0] m_result_y,
    output logic [plti_pkg::KIND_W-1:0]        m_segment_kind,
    input  wire                                cfg_wr_en,
    input  wire  [plti_pkg::CFG_W-1:0]         cfg_wr_data
);

    localparam int DW     = plti_pkg::DATA_W;
    localparam int MW     = DW + 1;
    localparam int PW     = 2 * MW;
    localparam int IDX_W  = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int WIDE_W = (IDX_W + 1 > plti_pkg::CFG_W) ? IDX_W + 1 : plti_pkg::CFG_W;
    localparam int CNT_W  = $clog2(PW);

    localparam logic [WIDE_W-1:0] DEPTH_W  = WIDE_W'(TABLE_DEPTH);
    localparam logic [CNT_W-1:0]  MUL_LAST = CNT_W'(MW - 1);
    localparam logic [CNT_W-1:0]  DIV_LAST = CNT_W'(PW - 1);

    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_RD0  = 4'd1;
    localparam logic [3:0] ST_RDL  = 4'd2;
    localparam logic [3:0] ST_DIR  = 4'd3;
    localparam logic [3:0] ST_SCAN = 4'd4;
    localparam logic [3:0] ST_MUL  = 4'd5;
    localparam logic [3:0] ST_DIV  = 4'd6;
    localparam logic [3:0] ST_FIN  = 4'd7;
    localparam logic [3:0] ST_OUT  = 4'd8;

    // table
    plti_pkg::sample_t mem_x [TABLE_DEPTH];
    plti_pkg::sample_t mem_y [TABLE_DEPTH];
    plti_pkg::sample_t rd_x_reg, rd_y_reg;
    logic [IDX_W-1:0]  rd_addr;
    logic              wr_en;
    logic [WIDE_W-1:0] wr_idx_w;

    // control
    logic [3:0]                  state_reg, state_next;
    logic [plti_pkg::CFG_W-1:0]  points_reg;
    logic                        m_valid_reg, m_valid_next;
    logic [IDX_W-1:0]            idx_reg, idx_next;
    logic [CNT_W-1:0]            cnt_reg, cnt_next;

    // datapath
    logic [IDX_W-1:0]            last_reg, last_next;
    plti_pkg::sample_t           q_reg, q_next;
    plti_pkg::sample_t           x0_reg, x0_next;
    logic                        asc_reg, asc_next;
    plti_pkg::sample_t           prev_x_reg, prev_x_next;
    plti_pkg::sample_t           prev_y_reg, prev_y_next;
    logic [MW-1:0]               mag_a_reg, mag_a_next;
    logic [MW-1:0]               mag_d_reg, mag_d_next;
    logic                        neg_reg, neg_next;
    logic [PW:0]                 acc_reg, acc_next;
    logic [MW-1:0]               rem_reg, rem_next;
    logic [PW-1:0]               dvd_reg, dvd_next;
    plti_pkg::sample_t           res_reg, res_next;
    logic [plti_pkg::KIND_W-1:0] kind_reg, kind_next;
    plti_pkg::sample_t           m_res_reg, m_res_next;
    logic [plti_pkg::KIND_W-1:0] m_kind_reg, m_kind_next;

    logic [WIDE_W-1:0] pin_w, n_w, last_w;
    logic              hit;
    logic [MW-1:0]     dy, dq, dx;
    logic [MW+1:0]     mul_sum;
    logic [MW:0]       div_sh;
    logic              div_ge;
    logic [MW-1:0]     quo, quo_s;
    logic [DW-1:0]     res_w;

    assign s_ready        = (state_reg == ST_IDLE);
    assign m_valid        = m_valid_reg;
    assign m_result_y     = m_res_reg;
    assign m_segment_kind = m_kind_reg;

    assign wr_idx_w = WIDE_W'(s_point_index);
    assign wr_en    = s_valid && s_ready && (s_cmd == plti_pkg::CMD_WRITE) && (wr_idx_w < DEPTH_W);

    assign pin_w  = WIDE_W'(points_reg);
    assign n_w    = (pin_w == '0) ? WIDE_W'(1) : ((pin_w > DEPTH_W) ? DEPTH_W : pin_w);
    assign last_w = n_w - WIDE_W'(1);

    assign hit = asc_reg ? (q_reg <= rd_x_reg) : (q_reg >= rd_x_reg);
    assign dy  = {rd_y_reg[DW-1], rd_y_reg} - {prev_y_reg[DW-1], prev_y_reg};
    assign dq  = {q_reg[DW-1], q_reg} - {prev_x_reg[DW-1], prev_x_reg};
    assign dx  = {rd_x_reg[DW-1], rd_x_reg} - {prev_x_reg[DW-1], prev_x_reg};

    assign mul_sum = {1'b0, acc_reg[PW:MW]} + (acc_reg[0] ? {2'b00, mag_a_reg} : '0);
    assign div_sh  = {rem_reg, dvd_reg[PW-1]};
    assign div_ge  = (div_sh >= {1'b0, mag_d_reg});

    assign quo   = dvd_reg[MW-1:0];
    assign quo_s = neg_reg ? (MW'(0) - quo) : quo;
    assign res_w = prev_y_reg + quo_s[DW-1:0];

    always_comb begin
        case (state_reg)
            ST_RD0:  rd_addr = '0;
            ST_RDL:  rd_addr = last_reg;
            ST_SCAN: rd_addr = IDX_W'(idx_reg + 1'b1);
            default: rd_addr = '0;
        endcase
    end

    always_comb begin
        state_next   = state_reg;
        m_valid_next = m_valid_reg && !m_ready;
        idx_next     = idx_reg;
        cnt_next     = cnt_reg;
        last_next    = last_reg;
        q_next       = q_reg;
        x0_next      = x0_reg;
        asc_next     = asc_reg;
        prev_x_next  = prev_x_reg;
        prev_y_next  = prev_y_reg;
        mag_a_next   = mag_a_reg;
        mag_d_next   = mag_d_reg;
        neg_next     = neg_reg;
        acc_next     = acc_reg;
        rem_next     = rem_reg;
        dvd_next     = dvd_reg;
        res_next     = res_reg;
        kind_next    = kind_reg;
        m_res_next   = m_res_reg;
        m_kind_next  = m_kind_reg;

        case (state_reg)
            ST_IDLE: begin
                if (s_valid && s_cmd == plti_pkg::CMD_QUERY) begin
                    q_next     = s_query_x;
                    last_next  = last_w[IDX_W-1:0];
                    state_next = ST_RD0;
                end
            end
            ST_RD0: begin
                state_next = ST_RDL;
            end
            ST_RDL: begin
                x0_next    = rd_x_reg;
                state_next = ST_DIR;
            end
            ST_DIR: begin
                asc_next   = (x0_reg < rd_x_reg);
                idx_next   = '0;
                state_next = ST_SCAN;
            end
            ST_SCAN: begin
                if (hit) begin
                    if (idx_reg == '0) begin
                        res_next   = rd_y_reg;
                        kind_next  = plti_pkg::KIND_FIRST;
                        state_next = ST_OUT;
                    end else if (rd_x_reg == prev_x_reg) begin
                        // zero span guard
                        res_next   = prev_y_reg;
                        kind_next  = plti_pkg::KIND_INTERP;
                        state_next = ST_OUT;
                    end else begin
                        mag_a_next = dy[MW-1] ? (MW'(0) - dy) : dy;
                        mag_d_next = dx[MW-1] ? (MW'(0) - dx) : dx;
                        neg_next   = dy[MW-1] ^ dq[MW-1] ^ dx[MW-1];
                        acc_next   = {{(MW+1){1'b0}}, (dq[MW-1] ? (MW'(0) - dq) : dq)};
                        cnt_next   = '0;
                        state_next = ST_MUL;
                    end
                end else begin
                    prev_x_next = rd_x_reg;
                    prev_y_next = rd_y_reg;
                    if (idx_reg == last_reg) begin
                        res_next   = rd_y_reg;
                        kind_next  = plti_pkg::KIND_LAST;
                        state_next = ST_OUT;
                    end else begin
                        idx_next = IDX_W'(idx_reg + 1'b1);
                    end
                end
            end
            ST_MUL: begin
                acc_next = {mul_sum, acc_reg[MW-1:1]};
                cnt_next = CNT_W'(cnt_reg + 1'b1);
                if (cnt_reg == MUL_LAST) begin
                    rem_next   = '0;
                    dvd_next   = {mul_sum[PW-MW:0], acc_reg[MW-1:1]};
                    cnt_next   = '0;
                    state_next = ST_DIV;
                end
            end
            ST_DIV: begin
                rem_next = div_ge ? MW'(div_sh - {1'b0, mag_d_reg}) : div_sh[MW-1:0];
                dvd_next = {dvd_reg[PW-2:0], div_ge};
                cnt_next = CNT_W'(cnt_reg + 1'b1);
                if (cnt_reg == DIV_LAST) begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN: begin
                res_next   = res_w;
                kind_next  = plti_pkg::KIND_INTERP;
                state_next = ST_OUT;
            end
            ST_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_res_next   = res_reg;
                    m_kind_next  = kind_reg;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_x[wr_idx_w[IDX_W-1:0]] <= s_point_x;
            mem_y[wr_idx_w[IDX_W-1:0]] <= s_point_y;
        end
        rd_x_reg <= mem_x[rd_addr];
        rd_y_reg <= mem_y[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
            points_reg  <= plti_pkg::POINTS_RESET;
            idx_reg     <= '0;
            cnt_reg     <= '0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            idx_reg     <= idx_next;
            cnt_reg     <= cnt_next;
            if (cfg_wr_en) begin
                points_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        last_reg   <= last_next;
        q_reg      <= q_next;
        x0_reg     <= x0_next;
        asc_reg    <= asc_next;
        prev_x_reg <= prev_x_next;
        prev_y_reg <= prev_y_next;
        mag_a_reg  <= mag_a_next;
        mag_d_reg  <= mag_d_next;
        neg_reg    <= neg_next;
        acc_reg    <= acc_next;
        rem_reg    <= rem_next;
        dvd_reg    <= dvd_next;
        res_reg    <= res_next;
        kind_reg   <= kind_next;
        m_res_reg  <= m_res_next;
        m_kind_reg <= m_kind_next;
    end

endmodule

`default_nettype wire

FILE: sv/plti_checker.sv
// Port-level assertions for the interpolator core, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module plti_checker (
    input wire                                aclk,
    input wire                                aresetn,
    input wire                                s_valid,
    input wire                                s_ready,
    input wire                                s_cmd,
    input wire                                m_valid,
    input wire                                m_ready,
    input wire signed [plti_pkg::DATA_W-1:0]  m_result_y,
    input wire [plti_pkg::KIND_W-1:0]         m_segment_kind
);

    // kind code 3 is never produced
    a_kind_legal: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_segment_kind == plti_pkg::KIND_INTERP ||
                     m_segment_kind == plti_pkg::KIND_FIRST ||
                     m_segment_kind == plti_pkg::KIND_LAST))
        else $error("illegal segment kind");

    // a query request keeps the block busy for at least the next cycle
    a_query_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && s_cmd == plti_pkg::CMD_QUERY) |=> !s_ready)
        else $error("ready after query request");

    // a write request creates no result
    a_write_silent: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && s_cmd == plti_pkg::CMD_WRITE && !m_valid) |=> !m_valid)
        else $error("result after write request");

    // a stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_result_y) && $stable(m_segment_kind)))
        else $error("result dropped or changed while stalled");

endmodule

bind piecewise_linear_table_interpolator_core plti_checker u_plti_checker (
    .aclk           (aclk),
    .aresetn        (aresetn),
    .s_valid        (s_valid),
    .s_ready        (s_ready),
    .s_cmd          (s_cmd),
    .m_valid        (m_valid),
    .m_ready        (m_ready),
    .m_result_y     (m_result_y),
    .m_segment_kind (m_segment_kind)
);

`default_nettype wire

FILE: sim/testbench.sv
// Self-checking testbench for the piecewise linear table interpolator core.
`timescale 1ns / 1ps

module testbench;

    typedef plti_pkg::sample_t sample_t;

    localparam int KIND_W          = plti_pkg::KIND_W;
    localparam int IDX_IN_W        = plti_pkg::IDX_IN_W;
    localparam int CFG_W           = plti_pkg::CFG_W;
    localparam int TABLE_DEPTH_DEF = plti_pkg::TABLE_DEPTH_DEF;

    localparam logic              CMD_WRITE    = plti_pkg::CMD_WRITE;
    localparam logic              CMD_QUERY    = plti_pkg::CMD_QUERY;
    localparam logic [KIND_W-1:0] KIND_INTERP  = plti_pkg::KIND_INTERP;
    localparam logic [KIND_W-1:0] KIND_FIRST   = plti_pkg::KIND_FIRST;
    localparam logic [KIND_W-1:0] KIND_LAST    = plti_pkg::KIND_LAST;
    localparam logic [CFG_W-1:0]  POINTS_RESET = plti_pkg::POINTS_RESET;

    localparam int  RANDOM_REQUESTS  = 400;
    localparam int  DIRECTED_COUNT   = 24;
    localparam int  SETTLE_CYCLES    = 200;
    localparam int  LONG_HOLD_CYCLES = 600;
    localparam int  HOLD_PHASE       = 3;
    localparam int  CYCLE_LIMIT      = 1000000;

    typedef struct packed {
        sample_t           y;
        logic [KIND_W-1:0] kind;
    } lookup_result_t;

    typedef struct packed {
        logic                cmd;
        logic [IDX_IN_W-1:0] idx;
        sample_t             px;
        sample_t             py;
        sample_t             qx;
        logic                typed;
        sample_t             exp_y;
        logic [KIND_W-1:0]   exp_kind;
    } stim_row_t;

    // typed rows carry an expectation that is obvious from the table contents
    localparam stim_row_t DIRECTED_ROWS [DIRECTED_COUNT] = '{
        '{CMD_WRITE, 6'd0, 32'h00000000, 32'h00000000, 32'h0, 1'b0, 32'h0, KIND_INTERP},
        '{CMD_WRITE, 6'd1, 32'h00010000, 32'h00020000, 32'h0, 1'b0, 32'h0, KIND_INTERP},
        '{CMD_QUERY, 6'd0, 32'h0, 32'h0, 32'hFFFFFFFF, 1'b1, 32'h00000000, KIND_FIRST},
        '{CMD_QUERY, 6'd0, 32'h0, 32'h0, 32'h00000000, 1'b1, 32'h00000000, KIND_FIRST},
        '{CMD_QUERY, 6'd0, 32'h0, 32'h0, 32'h00010001, 1'b1, 32'h00020000, KIND_LAST},
        '{CMD_QUERY, 6'd0, 32'h0, 32'h0, 32'h00008000, 1'b0, 32'h0, KIND_INTERP},
        '{CMD_QUERY, 6'd0, 32'h0, 32'h0, 32'h00010000, 1'b0, 32'h0, KIND_INTERP},
        '{CMD_QUERY, 6'd0, 32'h0, 32'h0, 32'h80000000, 1'b1, 32'h00000000, KIND_FIRST},
        '{CMD_QUERY, 6'd0, 32'h0, 32'h0, 32'h7FFFFFFF, 1'b1, 32'h00020000, KIND_LAST},
        '{CMD_WRITE, 6'd0, 32'h80000000, 32'h7FFFFFFF, 32'h0, 1'b0, 32'h0, KIND_INTERP},
        '{CMD_WRITE, 6'd1, 32'h7FFFFFFF, 32'h80000000, 32'h0, 1'b0, 32'h0, KIND_INTERP},
        '{CMD_QUERY, 6'd0, 32'h0, 32'h0, 32'h00000000, 1'b0, 32'h0, KIND_INTERP},
        '{CMD_QUERY, 6'd0, 32'h0, 32'h0, 32'h80000000, 1'b1, 32'h7FFFFFFF, KIND_FIRST},
        '{CMD_QUERY, 6'd0, 32'h0, 32'h0, 32'h7FFFFFFF, 1'b0, 32'h0, KIND_INTERP},
        '{CMD_WRITE, 6'd0, 32'h00010000, 32'h00000005, 32'h0, 1'b0, 32'h0, KIND_INTERP},
        '{CMD_WRITE, 6'd1, 32'hFFFF0000, 32'hFFFFFFF9, 32'h0, 1'b0, 32'h0, KIND_INTERP},
        '{CMD_QUERY, 6'd0, 32'h0, 32'h0, 32'h00020000, 1'b1, 32'h00000005, KIND_FIRST},
        '{CMD_QUERY, 6'd0, 32'h0, 32'h0, 32'hFFFE0000, 1'b1, 32'hFFFFFFF9, KIND_LAST},
        '{CMD_QUERY, 6'd0, 32'h0, 32'h0, 32'h00000000, 1'b0, 32'h0, KIND_INTERP},
        '{CMD_QUERY, 6'd0, 32'h0, 32'h0, 32'h00000001, 1'b0, 32'h0, KIND_INTERP},
        '{CMD_WRITE, 6'd0, 32'h00030000, 32'h00000001, 32'h0, 1'b0, 32'h0, KIND_INTERP},
        '{CMD_WRITE, 6'd1, 32'h00030000, 32'h00000002, 32'h0, 1'b0, 32'h0, KIND_INTERP},
        '{CMD_QUERY, 6'd0, 32'h0, 32'h0, 32'h00030000, 1'b1, 32'h00000001, KIND_FIRST},
        '{CMD_QUERY, 6'd0, 32'h0, 32'h0, 32'h0002FFFF, 1'b1, 32'h00000002, KIND_LAST}
    };

    localparam logic [CFG_W-1:0] CFG_SWEEP [7] = '{7'd1, 7'd64, 7'd0, 7'd2, 7'd127, 7'd3, 7'd16};

    logic                aclk;
    logic                aresetn        = 1'b0;
    logic                s_valid        = 1'b0;
    logic                s_ready;
    logic                s_cmd          = CMD_WRITE;
    logic [IDX_IN_W-1:0] s_point_index  = '0;
    sample_t             s_point_x      = '0;
    sample_t             s_point_y      = '0;
    sample_t             s_query_x      = '0;
    logic                m_valid;
    logic                m_ready        = 1'b0;
    sample_t             m_result_y;
    logic [KIND_W-1:0]   m_segment_kind;
    logic                cfg_wr_en      = 1'b0;
    logic [CFG_W-1:0]    cfg_wr_data    = POINTS_RESET;

    // predictor copy of the breakpoint table and register
    sample_t          bp_x [TABLE_DEPTH_DEF];
    sample_t          bp_y [TABLE_DEPTH_DEF];
    logic [CFG_W-1:0] points_cfg = POINTS_RESET;

    lookup_result_t pending_results [$];
    lookup_result_t oldest;
    lookup_result_t seen;

    int  request_count   = 0;
    int  query_count     = 0;
    int  write_count     = 0;
    int  checked_count   = 0;
    int  mismatch_count  = 0;
    int  cfg_write_count = 0;
    int  kind_tally [3]  = '{0, 0, 0};
    int  cycle_count     = 0;
    int  send_idle_pct   = 20;
    int  recv_idle_pct   = 20;
    int  stall_left      = 0;
    int  hold_left       = 0;
    bit  idle_on         = 1'b1;
    bit  long_hold_req   = 1'b0;

    piecewise_linear_table_interpolator_core uut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_cmd          (s_cmd),
        .s_point_index  (s_point_index),
        .s_point_x      (s_point_x),
        .s_point_y      (s_point_y),
        .s_query_x      (s_query_x),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_result_y     (m_result_y),
        .m_segment_kind (m_segment_kind),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    function automatic int points_effective(input logic [CFG_W-1:0] v);
        if (v == 0) return 1;
        if (v > TABLE_DEPTH_DEF) return TABLE_DEPTH_DEF;
        return int'(v);
    endfunction

    function automatic lookup_result_t interpolate(input sample_t q);
        lookup_result_t r;
        int n, last, i;
        bit rising, neg;
        logic signed [33:0] ya, yb, xa, xb, qw, dy, dq, dx;
        logic [33:0] mdy, mdq, mdx;
        logic [67:0] quot;
        longint acc;
        n = points_effective(points_cfg);
        last = n - 1;
        rising = bp_x[0] < bp_x[last];
        i = 0;
        while (i < n && !(rising ? (q <= bp_x[i]) : (q >= bp_x[i])))
            i++;
        if (i == 0) begin
            r.y = bp_y[0];
            r.kind = KIND_FIRST;
        end else if (i >= n) begin
            r.y = bp_y[last];
            r.kind = KIND_LAST;
        end else begin
            ya = 34'(bp_y[i-1]);
            yb = 34'(bp_y[i]);
            xa = 34'(bp_x[i-1]);
            xb = 34'(bp_x[i]);
            qw = 34'(q);
            dy = yb - ya;
            dq = qw - xa;
            dx = xb - xa;
            acc = longint'(bp_y[i-1]);
            if (dx != 0) begin
                mdy = (dy < 0) ? -dy : dy;
                mdq = (dq < 0) ? -dq : dq;
                mdx = (dx < 0) ? -dx : dx;
                quot = (68'(mdy) * 68'(mdq)) / 68'(mdx);
                neg = ((dy < 0) != (dq < 0)) != (dx < 0);
                if (dy == 0 || dq == 0)
                    neg = 1'b0;
                acc = neg ? acc - longint'(quot) : acc + longint'(quot);
            end
            r.y = acc[31:0];
            r.kind = KIND_INTERP;
        end
        return r;
    endfunction

    function automatic longint clamp_x(input longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function automatic sample_t pick_level();
        if ($urandom_range(0, 1) == 0) return sample_t'($urandom);
        return sample_t'(int'($urandom_range(0, 20'hFFFFF)) - 20'h80000);
    endfunction

    function automatic int pick_idle_pct();
        case ($urandom_range(0, 3))
            0: return 0;
            1: return 5;
            2: return 20;
            default: return 40;
        endcase
    endfunction

    function automatic sample_t pick_query(input int n);
        int k;
        longint lo, hi, t;
        longint unsigned r64;
        r64 = {$urandom, $urandom};
        k = $urandom_range(0, n - 1);
        case ($urandom_range(0, 9))
            0, 1: return sample_t'($urandom);
            2: return bp_x[k];
            3: return sample_t'(clamp_x(longint'(bp_x[k]) + int'($urandom_range(0, 2)) - 1));
            default: begin
                if (n < 2)
                    return sample_t'(clamp_x(longint'(bp_x[0]) + int'($urandom_range(0, 4)) - 2));
                k = $urandom_range(1, n - 1);
                lo = longint'(bp_x[k-1]);
                hi = longint'(bp_x[k]);
                if (lo > hi) begin
                    t = lo;
                    lo = hi;
                    hi = t;
                end
                return sample_t'(lo + longint'(r64 % longint'(hi - lo + 1)));
            end
        endcase
    endfunction

    task automatic report_mismatch(input string what, input lookup_result_t want,
                                   input lookup_result_t got);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("[%0t] %s: expected y=%0d kind=%0d, got y=%0d kind=%0d",
                     $time, what, want.y, want.kind, got.y, got.kind);
    endtask

    task automatic send_request(input logic cmd, input logic [IDX_IN_W-1:0] idx,
                                input sample_t px, input sample_t py, input sample_t qx,
                                input bit typed, input lookup_result_t typed_result);
        int gap;
        lookup_result_t want;
        gap = 0;
        if (idle_on && $urandom_range(0, 99) < send_idle_pct)
            gap = $urandom_range(1, 16);
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid       <= 1'b1;
        s_cmd         <= cmd;
        s_point_index <= idx;
        s_point_x     <= px;
        s_point_y     <= py;
        s_query_x     <= qx;
        do @(posedge aclk); while (!s_ready);
        request_count++;
        if (cmd == CMD_WRITE) begin
            bp_x[idx] = px;
            bp_y[idx] = py;
            write_count++;
        end else begin
            want = typed ? typed_result : interpolate(qx);
            pending_results.push_back(want);
            query_count++;
        end
    endtask

    // drop valid, wait for every pending result, then let the core settle
    task automatic quiesce();
        s_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic program_points(input logic [CFG_W-1:0] v);
        cfg_wr_data <= v;
        cfg_wr_en   <= 1'b1;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        points_cfg = v;
        cfg_write_count++;
    endtask

    task automatic build_table(input int n);
        longint xs [TABLE_DEPTH_DEF];
        longint step_max, room;
        longint unsigned r64;
        int shape, k, slot;
        bit reverse_order;
        shape = $urandom_range(0, 9);
        reverse_order = ($urandom_range(0, 1) == 1);
        step_max = longint'(1) << $urandom_range(0, 26);
        room = 64'sd4294967296 - longint'(n - 1) * step_max;
        r64 = {$urandom, $urandom};
        xs[0] = longint'(r64 % room) - 64'sd2147483648;
        for (k = 1; k < n; k++)
            xs[k] = xs[k-1] + longint'($urandom_range(1, int'(step_max)));
        for (k = 0; k < n; k++) begin
            slot = reverse_order ? n - 1 - k : k;
            case (shape)
                6, 7: send_request(CMD_WRITE, slot[IDX_IN_W-1:0], sample_t'(xs[n-1-slot]),
                                   pick_level(), sample_t'($urandom), 1'b0, '0);
                8: send_request(CMD_WRITE, slot[IDX_IN_W-1:0], sample_t'($urandom),
                                pick_level(), sample_t'($urandom), 1'b0, '0);
                9: send_request(CMD_WRITE, slot[IDX_IN_W-1:0], sample_t'(xs[0]),
                                pick_level(), sample_t'($urandom), 1'b0, '0);
                default: send_request(CMD_WRITE, slot[IDX_IN_W-1:0], sample_t'(xs[slot]),
                                      pick_level(), sample_t'($urandom), 1'b0, '0);
            endcase
        end
    endtask

    initial begin
        stim_row_t row;
        logic [CFG_W-1:0] cfg_value;
        int r, phase, n, nq, k;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (r = 0; r < DIRECTED_COUNT; r++) begin
            row = DIRECTED_ROWS[r];
            send_request(row.cmd, row.idx, row.px, row.py, row.qx, row.typed,
                         {row.exp_y, row.exp_kind});
        end

        phase = 0;
        while (request_count < DIRECTED_COUNT + RANDOM_REQUESTS) begin
            if (request_count >= DIRECTED_COUNT + RANDOM_REQUESTS * 4 / 5)
                idle_on = 1'b0;
            quiesce();
            if (phase < 7)
                cfg_value = CFG_SWEEP[phase];
            else if ($urandom_range(0, 9) < 7)
                cfg_value = CFG_W'($urandom_range(1, 12));
            else if ($urandom_range(0, 1) == 0)
                cfg_value = CFG_W'($urandom_range(13, 63));
            else
                cfg_value = CFG_W'($urandom_range(64, 127));
            program_points(cfg_value);
            n = points_effective(cfg_value);
            send_idle_pct = pick_idle_pct();
            recv_idle_pct = pick_idle_pct();
            build_table(n);
            nq = $urandom_range(4, 24);
            if (phase == HOLD_PHASE) begin
                // receiver blocks while the sender keeps offering queries
                send_idle_pct = 0;
                nq = 16;
                long_hold_req = 1'b1;
            end
            for (k = 0; k < nq; k++) begin
                if (phase != HOLD_PHASE && $urandom_range(0, 9) == 0)
                    send_request(CMD_WRITE, IDX_IN_W'($urandom_range(0, TABLE_DEPTH_DEF - 1)),
                                 sample_t'($urandom), pick_level(), sample_t'($urandom),
                                 1'b0, '0);
                else
                    send_request(CMD_QUERY, IDX_IN_W'($urandom), sample_t'($urandom),
                                 sample_t'($urandom), pick_query(n), 1'b0, '0);
            end
            phase++;
        end

        quiesce();
        $display("Covered %0d requests (%0d queries, %0d writes) over %0d table sizes",
                 request_count, query_count, write_count, cfg_write_count);
        $display("Checked %0d results: %0d interpolated, %0d clamped low, %0d clamped high",
                 checked_count, kind_tally[0], kind_tally[1], kind_tally[2]);
        if (mismatch_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    always @(posedge aclk) begin
        if (long_hold_req) begin
            long_hold_req = 1'b0;
            hold_left = LONG_HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            m_ready <= 1'b0;
        end else if (idle_on && $urandom_range(0, 99) < recv_idle_pct) begin
            stall_left = $urandom_range(1, 16) - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            seen = {m_result_y, m_segment_kind};
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected result", '0, seen);
            end else begin
                oldest = pending_results.pop_front();
                checked_count++;
                kind_tally[oldest.kind]++;
                if (seen !== oldest)
                    report_mismatch("result mismatch", oldest, seen);
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d results outstanding",
                     cycle_count, pending_results.size());
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

endmodule
